// File: sv/day_count_between_dates_defines.svh
// Assertion helpers used by the file that checks its own logic.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef DAY_COUNT_BETWEEN_DATES_DEFINES_SVH
`define DAY_COUNT_BETWEEN_DATES_DEFINES_SVH

// Same-cycle implication.
`define DAYCNT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DAYCNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/daycnt_pkg.sv
package daycnt_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned COUNT_W   = 22;
  localparam int unsigned DN_W      = 23;  // day number, room for out-of-range years
  localparam int unsigned CENT_W    = 8;   // year / 100 for any 14-bit year
  localparam int unsigned QUAD_W    = 13;  // (year + 399) / 4

  localparam int unsigned MAX_YEAR    = 9999;
  localparam int unsigned YEAR_OFFSET = 400;
  localparam int unsigned RECIP_100   = 5243;  // 2^19 / 100, rounded up
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned MAX_COUNT   = 3652424;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_DATE = 2'd1,
    ERR_ORDER    = 2'd2
  } err_t;

  // Load strobes for the four per-date stages.
  typedef struct packed {
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

  // Month length; zero for a month code outside 1..12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before m in a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// File: sv/day_count_between_dates.sv
// Gregorian day difference, streaming.
// Input channel (in_*): one item carries a start date and an end date, each
// as year 0..9999, month 1..12 and day 1..month length. Output channel
// (out_*): one item per input item, in order: the day count from the start
// date to the end date in out_tdata and a status code in out_tuser
// (0 ok, 1 a field of either date is out of range, 2 end date before start
// date). On any nonzero status the count is zero. A range error wins over
// an order error.
// Three stages per date build a closed-form day number (range checks and
// year / 100 by reciprocal, leap rules, year sum), a fourth finishes it with
// the month and day sums, and the output register holds the difference.
// Throughput is one item per cycle while the receiver takes items.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up under a stall. When the receiver
// stalls, the output item holds; in_tready drops only once all five stages
// hold items. Reset (rst_n low, synchronous) clears every valid bit and
// drops whatever items were in flight; data registers are not reset.
`include "day_count_between_dates_defines.svh"

module day_count_between_dates (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] earlier_year, [17:14] earlier_month, [22:18] earlier_day,
  // [36:23] later_year, [40:37] later_month, [45:41] later_day, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [21:0] day_count, [23:22] zero
  output logic [23:0] out_tdata,
  // [1:0] error_code
  output logic [1:0]  out_tuser
);

  localparam int unsigned NSTG = 5;  // four date stages plus the output register

  // Unpack the input item.
  logic [daycnt_pkg::YEAR_W-1:0]  earlier_year, later_year;
  logic [daycnt_pkg::MONTH_W-1:0] earlier_month, later_month;
  logic [daycnt_pkg::DAY_W-1:0]   earlier_day, later_day;

  assign earlier_year  = in_tdata[13:0];
  assign earlier_month = in_tdata[17:14];
  assign earlier_day   = in_tdata[22:18];
  assign later_year    = in_tdata[36:23];
  assign later_month   = in_tdata[40:37];
  assign later_day     = in_tdata[45:41];

  // Valid chain: stage k advances when empty or when stage k+1 advances.
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  daycnt_pkg::stage_en_t stg_en;

  assign stg_en.s1 = rdy[0];
  assign stg_en.s2 = rdy[1];
  assign stg_en.s3 = rdy[2];
  assign stg_en.s4 = rdy[3];

  // Two date lanes in lockstep.
  logic [daycnt_pkg::DN_W-1:0] start_num, end_num;
  logic                        start_ok, end_ok;

  daycnt_date_unit u_start (
    .clk     (clk),
    .en      (stg_en),
    .year    (earlier_year),
    .month   (earlier_month),
    .day     (earlier_day),
    .day_num (start_num),
    .date_ok (start_ok)
  );

  daycnt_date_unit u_end (
    .clk     (clk),
    .en      (stg_en),
    .year    (later_year),
    .month   (later_month),
    .day     (later_day),
    .day_num (end_num),
    .date_ok (end_ok)
  );

  // Output register: difference and status.
  logic [daycnt_pkg::COUNT_W-1:0] day_count;
  daycnt_pkg::err_t               error_code;

  daycnt_diff u_diff (
    .clk        (clk),
    .en         (rdy[NSTG-1]),
    .start_num  (start_num),
    .start_ok   (start_ok),
    .end_num    (end_num),
    .end_ok     (end_ok),
    .day_count  (day_count),
    .error_code (error_code)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {2'b00, day_count};
  assign out_tuser  = error_code;

  // Checks
  `DAYCNT_ASSERT_IMPLIES(a_err_zero_count, out_tvalid && (error_code != daycnt_pkg::ERR_NONE), day_count == '0, "nonzero count with error status")
  `DAYCNT_ASSERT_IMPLIES(a_count_range, out_tvalid, day_count <= daycnt_pkg::COUNT_W'(daycnt_pkg::MAX_COUNT), "day count out of range")
  `DAYCNT_ASSERT_IMPLIES(a_stall_full, !in_tready, (&vld_r) && !out_tready, "input stalled with a free stage")
  `DAYCNT_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0], "accepted item not in first stage")

endmodule

// File: sv/daycnt_date_unit.sv
module daycnt_date_unit (
  input  logic                                clk,
  input  daycnt_pkg::stage_en_t               en,
  input  logic [daycnt_pkg::YEAR_W-1:0]       year,
  input  logic [daycnt_pkg::MONTH_W-1:0]      month,
  input  logic [daycnt_pkg::DAY_W-1:0]        day,
  output logic [daycnt_pkg::DN_W-1:0]         day_num,
  output logic                                date_ok
);

  localparam int unsigned PROD_W = daycnt_pkg::YEAR_W + 13;
  localparam int unsigned YS_W   = daycnt_pkg::YEAR_W + 1;

  // Stage 1: range checks, year / 100 by reciprocal
  logic [PROD_W-1:0]                  cent_prod;
  logic [daycnt_pkg::YEAR_W-1:0]      y1_r;
  logic [daycnt_pkg::MONTH_W-1:0]     m1_r;
  logic [daycnt_pkg::DAY_W-1:0]       d1_r;
  logic [daycnt_pkg::CENT_W-1:0]      q1_r;
  logic                               rng1_r;

  assign cent_prod = PROD_W'(year) * PROD_W'(daycnt_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1_r   <= year;
      m1_r   <= month;
      d1_r   <= day;
      q1_r   <= cent_prod[daycnt_pkg::RECIP_SHIFT +: daycnt_pkg::CENT_W];
      rng1_r <= (year <= daycnt_pkg::YEAR_W'(daycnt_pkg::MAX_YEAR)) &&
                (month >= daycnt_pkg::MONTH_JAN) && (month <= daycnt_pkg::MONTH_DEC) &&
                (day != '0);
    end
  end

  // Stage 2: leap year, leap counts of the offset year, day-in-month check
  logic [6:0]                         rem100;
  logic                               leap;
  logic [daycnt_pkg::CENT_W-1:0]      p100;
  logic [YS_W-1:0]                    ys;
  logic [YS_W-1:0]                    pm1;
  logic [YS_W-1:0]                    ys2_r;
  logic [daycnt_pkg::QUAD_W-1:0]      p4_2_r;
  logic [daycnt_pkg::CENT_W-1:0]      p100_2_r;
  logic                               leap2_r;
  logic [daycnt_pkg::MONTH_W-1:0]     m2_r;
  logic [daycnt_pkg::DAY_W-1:0]       d2_r;
  logic                               ok2_r;

  always_comb begin
    rem100 = 7'(y1_r - daycnt_pkg::YEAR_W'(q1_r * 8'd100));
    leap   = (y1_r[1:0] == 2'b00) && ((rem100 != 7'd0) || (q1_r[1:0] == 2'b00));
    // (y + 399) / 100 = y / 100 + 3, plus one unless y is a whole century
    p100   = q1_r + daycnt_pkg::CENT_W'(3) + daycnt_pkg::CENT_W'(rem100 != 7'd0);
    ys     = YS_W'(y1_r) + YS_W'(daycnt_pkg::YEAR_OFFSET);
    pm1    = ys - YS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      ys2_r    <= ys;
      p4_2_r   <= pm1[YS_W-1:2];
      p100_2_r <= p100;
      leap2_r  <= leap;
      m2_r     <= m1_r;
      d2_r     <= d1_r;
      ok2_r    <= rng1_r && (d1_r <= daycnt_pkg::month_len(m1_r, leap));
    end
  end

  // Stage 3: day number of January 0 of the offset year
  logic [daycnt_pkg::DN_W-1:0]        ny3_r;
  logic                               leap3_r;
  logic [daycnt_pkg::MONTH_W-1:0]     m3_r;
  logic [daycnt_pkg::DAY_W-1:0]       d3_r;
  logic                               ok3_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ny3_r   <= daycnt_pkg::DN_W'(ys2_r) * daycnt_pkg::DN_W'(365) +
                 daycnt_pkg::DN_W'(p4_2_r) - daycnt_pkg::DN_W'(p100_2_r) +
                 daycnt_pkg::DN_W'(p100_2_r[daycnt_pkg::CENT_W-1:2]);
      leap3_r <= leap2_r;
      m3_r    <= m2_r;
      d3_r    <= d2_r;
      ok3_r   <= ok2_r;
    end
  end

  // Stage 4: add month offset, leap day and day of month
  logic [daycnt_pkg::DN_W-1:0]        dn4_r;
  logic                               ok4_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      dn4_r <= ny3_r + daycnt_pkg::DN_W'(daycnt_pkg::days_before(m3_r)) +
               daycnt_pkg::DN_W'((m3_r > daycnt_pkg::MONTH_FEB) && leap3_r) +
               daycnt_pkg::DN_W'(d3_r);
      ok4_r <= ok3_r;
    end
  end

  assign day_num = dn4_r;
  assign date_ok = ok4_r;

endmodule

// File: sv/daycnt_diff.sv
module daycnt_diff (
  input  logic                              clk,
  input  logic                              en,
  input  logic [daycnt_pkg::DN_W-1:0]       start_num,
  input  logic                              start_ok,
  input  logic [daycnt_pkg::DN_W-1:0]       end_num,
  input  logic                              end_ok,
  output logic [daycnt_pkg::COUNT_W-1:0]    day_count,
  output daycnt_pkg::err_t                  error_code
);

  logic [daycnt_pkg::DN_W-1:0]    span;
  daycnt_pkg::err_t               err;
  logic [daycnt_pkg::COUNT_W-1:0] count_r;
  daycnt_pkg::err_t               err_r;

  always_comb begin
    span = end_num - start_num;
    if (!start_ok || !end_ok) begin
      err = daycnt_pkg::ERR_BAD_DATE;
    end else if (end_num < start_num) begin
      err = daycnt_pkg::ERR_ORDER;
    end else begin
      err = daycnt_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r   <= err;
      count_r <= (err == daycnt_pkg::ERR_NONE) ? span[daycnt_pkg::COUNT_W-1:0] : '0;
    end
  end

  assign day_count  = count_r;
  assign error_code = err_r;

endmodule
